// File: sv/sled_pkg.sv
`default_nettype none
package sled_pkg;

  localparam int MAX_STRING_BYTES = 1024;
  // count never exceeds MAX_STRING_BYTES-1
  localparam int CountW = (MAX_STRING_BYTES > 2) ? $clog2(MAX_STRING_BYTES) : 1;
  localparam int LenW = 10;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EARLY = 2'd1,
    ERR_LONG  = 2'd2,
    ERR_HEX   = 2'd3
  } err_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_X   = 8'h78;

  typedef struct packed {
    logic [7:0]     char_out;
    kind_t          kind;
    err_t           error_code;
    logic [LenW-1:0] string_length;
  } res_t;

  // input stage to decoder
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eoi;
  } in_item_t;

  // {not a hex digit, digit value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b1_0000;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    return r;
  endfunction

  function automatic logic [LenW-1:0] to_len(input count_t c);
    logic [CountW+LenW-1:0] ext;
    ext = {{LenW{1'b0}}, c};
    return ext[LenW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/sled_in_reg.sv
`default_nettype none
module sled_in_reg
  import sled_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_input,
  input  wire logic       advance,
  output in_item_t        item
);

  logic       vld;
  logic [7:0] data;
  logic       eoi;

  // stage can refill in the cycle its request moves on
  assign in_stall = vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!in_stall) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= byte_in;
      eoi  <= end_of_input;
    end
  end

  assign item = '{valid: vld, data: data, eoi: eoi};

endmodule
`default_nettype wire

// File: sv/sled_decode.sv
`default_nettype none
module sled_decode
  import sled_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  in_item_t  item,
  input  wire logic advance,
  output logic      emit,
  output res_t      res
);

  mode_t      mode, mode_next;
  count_t     count, count_next;
  logic [3:0] nibble, nibble_next;
  logic       nib_bad, nib_bad_next;
  logic [4:0] hv;
  logic [7:0] ch;
  logic       do_char;
  count_t     count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PLAIN;
      count   <= '0;
      nibble  <= '0;
      nib_bad <= 1'b0;
    end else if (advance) begin
      mode    <= mode_next;
      count   <= count_next;
      nibble  <= nibble_next;
      nib_bad <= nib_bad_next;
    end
  end

  assign hv        = hex_value(item.data);
  assign count_inc = count + count_t'(1);

  always_comb begin
    mode_next    = mode;
    count_next   = count;
    nibble_next  = nibble;
    nib_bad_next = nib_bad;
    emit         = 1'b0;
    do_char      = 1'b0;
    ch           = item.data;
    res          = '{char_out: 8'h00, kind: KIND_ERR, error_code: ERR_NONE,
                     string_length: to_len(count)};

    if (item.eoi) begin
      emit           = 1'b1;
      res.error_code = ERR_EARLY;
    end else begin
      unique case (mode)
        MODE_PLAIN: begin
          if (item.data == CH_QUOTE) begin
            emit     = 1'b1;
            res.kind = KIND_END;
          end else if (count >= count_t'(MAX_STRING_BYTES - 1)) begin
            emit           = 1'b1;
            res.error_code = ERR_LONG;
          end else if (item.data == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            do_char = 1'b1;
          end
        end
        MODE_ESC: begin
          unique case (item.data)
            CH_NL:   mode_next = MODE_PLAIN;   // line continuation
            CH_LC_X: mode_next = MODE_HEX1;
            CH_LC_B: begin do_char = 1'b1; ch = 8'h08; end
            CH_LC_T: begin do_char = 1'b1; ch = 8'h09; end
            CH_LC_N: begin do_char = 1'b1; ch = 8'h0A; end
            CH_LC_V: begin do_char = 1'b1; ch = 8'h0B; end
            CH_LC_F: begin do_char = 1'b1; ch = 8'h0C; end
            CH_LC_R: begin do_char = 1'b1; ch = 8'h0D; end
            default: do_char = 1'b1;
          endcase
        end
        MODE_HEX1: begin
          nibble_next  = hv[3:0];
          nib_bad_next = hv[4];
          mode_next    = MODE_HEX2;
        end
        MODE_HEX2: begin
          if (nib_bad || hv[4]) begin
            emit           = 1'b1;
            res.error_code = ERR_HEX;
          end else begin
            do_char      = 1'b1;
            ch           = {nibble, hv[3:0]};
            nibble_next  = '0;
            nib_bad_next = 1'b0;
          end
        end
        default: mode_next = MODE_PLAIN;
      endcase
    end

    if (do_char) begin
      emit              = 1'b1;
      res.kind          = KIND_CHAR;
      res.char_out      = ch;
      res.string_length = to_len(count_inc);
      count_next        = count_inc;
      mode_next         = MODE_PLAIN;
    end else if (emit) begin
      // end or error: fresh start for the next string
      mode_next    = MODE_PLAIN;
      count_next   = '0;
      nibble_next  = '0;
      nib_bad_next = 1'b0;
    end

    if (!item.valid) emit = 1'b0;
  end

endmodule
`default_nettype wire

// File: sv/string_literal_escape_decoder.sv
// String literal escape decoder.
// Input channel: in_valid / in_stall carry one raw byte of a string body
// (after the opening quote) per request, or an end_of_input flag.
// Output channel: out_valid / out_stall carry at most one result per input
// request: a decoded character (kind 0), end of string with its length
// (kind 1), or an error (kind 2) with error_code set. Backslash-newline and
// the leading bytes of an escape produce no result.
// Path: each request is captured in the input register, then decoded into
// the result register; a request that produces a result waits in the input
// register while the result register is full and stalled.
// Throughput: one byte per cycle while no result waits on out_stall;
// the mode and count update is a single short step between the input register and the result register.
// The receiver may stall at any time; the result register holds and the
// input register still drains bytes that produce no result. Once both are
// full, in_stall rises in the same cycle as out_stall.
// Reset (rst, synchronous) empties both registers and returns the decoder
// to plain mode with a zero count. After an end or an error the decoder
// restarts by itself for the next string.
`default_nettype none
module string_literal_escape_decoder
  import sled_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      char_out,
  output logic [1:0]      kind,
  output logic [1:0]      error_code,
  output logic [9:0]      string_length
);

  in_item_t item;
  logic     advance;
  logic     emit;
  res_t     res;
  res_t     res_reg;
  logic     load;

  assign advance = item.valid && (!out_valid || !out_stall || !emit);
  assign load    = advance && emit;

  sled_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .advance      (advance),
    .item         (item)
  );

  sled_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_reg <= res;
    end
  end

  assign char_out      = res_reg.char_out;
  assign kind          = res_reg.kind;
  assign error_code    = res_reg.error_code;
  assign string_length = res_reg.string_length;

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_CHAR || kind == KIND_END || kind == KIND_ERR))
    else $error("illegal result kind");

  a_char_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERR |-> error_code == ERR_NONE)
    else $error("error code on non-error result");

  a_err_coded: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> error_code != ERR_NONE && char_out == 8'h00)
    else $error("error result malformed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !load)
    else $error("result register overwritten while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule
`default_nettype wire

// File: dv/tb_string_literal_escape_decoder.sv
`default_nettype none
module tb_string_literal_escape_decoder
  import sled_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_LEN = 300;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] CC_BACKSPACE = 8'h08;
  localparam logic [7:0] CC_TAB       = 8'h09;
  localparam logic [7:0] CC_NEWLINE   = 8'h0A;
  localparam logic [7:0] CC_VTAB      = 8'h0B;
  localparam logic [7:0] CC_FORMFEED  = 8'h0C;
  localparam logic [7:0] CC_RETURN    = 8'h0D;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] byte_in = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic [1:0] kind;
  logic [1:0] error_code;
  logic [9:0] string_length;

  string_literal_escape_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .byte_in(byte_in),
    .end_of_input(end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_out(char_out),
    .kind(kind),
    .error_code(error_code),
    .string_length(string_length)
  );

  // decoder state as predicted
  mode_t      pred_mode = MODE_PLAIN;
  int         pred_count = 0;
  logic [3:0] pred_hi = 4'h0;
  logic       pred_hi_bad = 1'b0;

  res_t decoded_due[$];
  int   n_sent = 0;
  int   n_bad = 0;
  int   hold_cycles = 0;
  bit   tx_idle_on = 1'b0;
  bit   rx_idle_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // -1 when not a hex digit
  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  task automatic push_result(input logic [7:0] ch, input kind_t k, input err_t code);
    res_t r;
    r.char_out = ch;
    r.kind = k;
    r.error_code = code;
    r.string_length = LenW'(pred_count);
    decoded_due.push_back(r);
  endtask

  task automatic restart_string();
    pred_mode = MODE_PLAIN;
    pred_count = 0;
    pred_hi = 4'h0;
    pred_hi_bad = 1'b0;
  endtask

  task automatic push_char(input logic [7:0] ch);
    pred_count++;
    pred_mode = MODE_PLAIN;
    push_result(ch, KIND_CHAR, ERR_NONE);
  endtask

  task automatic push_error(input err_t code);
    push_result(8'h00, KIND_ERR, code);
    restart_string();
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    int d;
    if (eoi) begin
      push_error(ERR_EARLY);
      return;
    end
    case (pred_mode)
      MODE_PLAIN: begin
        if (b == CH_QUOTE) begin
          push_result(8'h00, KIND_END, ERR_NONE);
          restart_string();
        end else if (pred_count >= MAX_STRING_BYTES - 1) begin
          // limit wins even over a backslash
          push_error(ERR_LONG);
        end else if (b == CH_BSLASH) begin
          pred_mode = MODE_ESC;
        end else begin
          push_char(b);
        end
      end
      MODE_ESC: begin
        case (b)
          CH_NL:   pred_mode = MODE_PLAIN;
          CH_LC_B: push_char(CC_BACKSPACE);
          CH_LC_T: push_char(CC_TAB);
          CH_LC_N: push_char(CC_NEWLINE);
          CH_LC_V: push_char(CC_VTAB);
          CH_LC_F: push_char(CC_FORMFEED);
          CH_LC_R: push_char(CC_RETURN);
          CH_LC_X: pred_mode = MODE_HEX1;
          default: push_char(b);
        endcase
      end
      MODE_HEX1: begin
        d = hex_digit(b);
        pred_hi_bad = (d < 0);
        pred_hi = (d < 0) ? 4'h0 : d[3:0];
        pred_mode = MODE_HEX2;
      end
      default: begin
        d = hex_digit(b);
        if (pred_hi_bad || d < 0) begin
          push_error(ERR_HEX);
        end else begin
          pred_hi_bad = 1'b0;
          push_char({pred_hi, d[3:0]});
          pred_hi = 4'h0;
        end
      end
    endcase
  endtask

  task automatic send_req(input logic [7:0] b, input logic eoi);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    byte_in <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    decode_byte(b, eoi);
    n_sent++;
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] rand_ctrl_letter();
    logic [7:0] letters[6] = '{CH_LC_B, CH_LC_T, CH_LC_N, CH_LC_V, CH_LC_F, CH_LC_R};
    return letters[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'(int'("0") + v);
    return upper ? 8'(int'("A") + v - 10) : 8'(int'("a") + v - 10);
  endfunction

  // n decoded characters, a few of them escapes
  task automatic fill_chars(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_req(CH_BSLASH, 1'b0);
        send_req(rand_ctrl_letter(), 1'b0);
      end else begin
        send_req(rand_plain(), 1'b0);
      end
    end
  endtask

  task automatic test_escapes();
    logic [7:0] seq[$] = '{8'h00, 8'hFF,
                           CH_BSLASH, CH_LC_B, CH_BSLASH, CH_LC_T, CH_BSLASH, CH_LC_N,
                           CH_BSLASH, CH_LC_V, CH_BSLASH, CH_LC_F, CH_BSLASH, CH_LC_R,
                           CH_BSLASH, CH_LC_X, 8'h66, 8'h46,
                           CH_BSLASH, CH_NL, CH_BSLASH, 8'hFF, CH_BSLASH, CH_QUOTE,
                           CH_QUOTE};
    foreach (seq[i]) send_req(seq[i], 1'b0);
  endtask

  task automatic test_errors();
    // empty string
    send_req(CH_QUOTE, 1'b0);
    // quote taken as the first hex digit
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_X, 1'b0);
    send_req(CH_QUOTE, 1'b0);
    send_req(8'h30, 1'b0);
    // bad second digit
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_X, 1'b0);
    send_req(8'h34, 1'b0);
    send_req(8'h67, 1'b0);
    // early end in each mode
    send_req(8'h61, 1'b0);
    send_req(8'hFF, 1'b1);
    send_req(CH_BSLASH, 1'b0);
    send_req(8'h00, 1'b1);
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_X, 1'b0);
    send_req(CH_QUOTE, 1'b1);
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_X, 1'b0);
    send_req(8'h31, 1'b0);
    send_req(CH_BSLASH, 1'b1);
  endtask

  // hex escape lands on the last allowed character, then a backslash is refused
  task automatic test_length_limit();
    fill_chars(MAX_STRING_BYTES - 2);
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_X, 1'b0);
    send_req(8'h34, 1'b0);
    send_req(8'h31, 1'b0);
    send_req(CH_BSLASH, 1'b0);
    send_req(8'h7A, 1'b0);
  endtask

  // receiver held off while requests keep coming, then a full drain
  task automatic test_backpressure();
    bit saved;
    saved = tx_idle_on;
    tx_idle_on = 1'b0;
    hold_cycles = HOLD_LEN;
    fill_chars(40);
    send_req(CH_QUOTE, 1'b0);
    wait_drained();
    tx_idle_on = saved;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) send_req(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
  endtask

  task automatic send_random_string();
    int n_pieces;
    int sel;
    bit ended;
    n_pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    ended = 1'b0;
    for (int i = 0; i < n_pieces && !ended; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        send_req(rand_plain(), 1'b0);
      end else if (sel < 62) begin
        send_req(CH_BSLASH, 1'b0);
        send_req(rand_ctrl_letter(), 1'b0);
      end else if (sel < 74) begin
        send_req(CH_BSLASH, 1'b0);
        send_req(CH_LC_X, 1'b0);
        send_req(hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0);
        send_req(hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0);
      end else if (sel < 80) begin
        send_req(CH_BSLASH, 1'b0);
        send_req(CH_NL, 1'b0);
      end else if (sel < 90) begin
        send_req(CH_BSLASH, 1'b0);
        send_req(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 96) begin
        send_req(CH_BSLASH, 1'b0);
        send_req(CH_LC_X, 1'b0);
        if ($urandom_range(0, 1)) begin
          send_req(8'($urandom_range(0, 255)), 1'b0);
          send_req(hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0);
        end else begin
          send_req(hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0);
          send_req(8'($urandom_range(0, 255)), 1'b0);
        end
      end else begin
        send_req(8'($urandom_range(0, 255)), 1'b1);
        ended = 1'b1;
      end
    end
    if (!ended) begin
      sel = $urandom_range(0, 99);
      if (sel < 90) send_req(CH_QUOTE, 1'b0);
      else if (sel < 95) send_req(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random(input int n_items);
    int start;
    start = n_sent;
    while (n_sent - start < n_items) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_string();
    end
  endtask

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 19) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic note_bad(input string msg);
    if (n_bad < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    n_bad++;
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (decoded_due.size() == 0) begin
        note_bad($sformatf("unexpected result char %02h kind %0d err %0d len %0d",
                           char_out, kind, error_code, string_length));
      end else begin
        e = decoded_due.pop_front();
        if (char_out !== e.char_out || kind !== e.kind || error_code !== e.error_code ||
            string_length !== e.string_length)
          note_bad($sformatf("mismatch exp char %02h kind %0d err %0d len %0d, got %02h %0d %0d %0d",
                             e.char_out, e.kind, e.error_code, e.string_length,
                             char_out, kind, error_code, string_length));
      end
    end
  end

  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_escapes();
    test_errors();
    wait_drained();
    test_length_limit();
    wait_drained();
    test_backpressure();
    test_random(300);
    wait_drained();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random(100);
    wait_drained();
    repeat (10) @(posedge clk);
    if (n_bad == 0 && decoded_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: string_literal_escape_decoder.f
sv/sled_pkg.sv
sv/sled_in_reg.sv
sv/sled_decode.sv
sv/string_literal_escape_decoder.sv
dv/tb_string_literal_escape_decoder.sv
